// File: design/greedy_box_suppression_defines.svh
// Assertion macros shared by the checker.
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define GBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define GBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: design/gbs_pkg.sv
`timescale 1ns / 1ps
package gbs_pkg;
  localparam int MaxBoxes = 64;
  localparam int IdxW = $clog2(MaxBoxes);
  localparam int CntW = $clog2(MaxBoxes + 1);
  localparam int CornerW = 64;
  localparam int ScoreW = 16;
  localparam int AreaW = 34;
  localparam int ThrW = 17;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPixelOffset = 1'b1;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic signed [15:0] right_x;
    logic signed [15:0] bottom_y;
    logic [15:0] box_score;
    logic is_last;
  } in_item_t;

  typedef struct packed {
    logic [5:0] kept_index;
    logic [6:0] kept_count;
    logic last_kept;
    logic boxes_dropped;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_NMS_RD, ST_NMS_KRD, ST_NMS_MUL,
    ST_NMS_PROD, ST_NMS_CMP, ST_NMS_WR, ST_EMIT_RD, ST_EMIT
  } state_t;
endpackage

// File: design/gbs_ram.sv
`timescale 1ns / 1ps
module gbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/greedy_box_suppression.sv
`timescale 1ns / 1ps
// Greedy non-maximum suppression over a set of up to 64 boxes.
// Boxes enter on the in_ channel, one item per cycle while loading. The set
// closes with the item that carries is_last. The block then ranks the boxes
// by descending score (a stable selection pass, reading the score memory
// once per box per pass), then walks the ranking and tests each box against
// the kept list, one kept box at a time (kept list read, kept box read,
// products, compare). Finally it sends one out_ item per kept box in rank
// order, each item carrying the count, a last flag and the overflow flag.
// The throughput is set by the memories, each with a single read port.
// in_ready is low from is_last until the final result has been taken.
// A stalled receiver simply holds the current result in the output register;
// the next kept index is read ahead but loaded only once the current one is taken.
// Reset (rst_n low, synchronous) empties the set, clears the overflow flag
// and restores the threshold to 0.5 and pixel_offset to zero. The memories
// are not cleared: only entries written in the current set are ever used.
module greedy_box_suppression (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gbs_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gbs_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [gbs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gbs_pkg::ThrW-1:0]   cfg_wdata
);
  import gbs_pkg::*;

  // Configuration registers.
  logic [ThrW-1:0] thr_r;
  logic            poff_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ThrW'(32768);
      poff_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegThreshold:   thr_r <= cfg_wdata;
        RegPixelOffset: poff_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [CntW-1:0] n_r, n_nxt;          // boxes loaded
  logic            ovf_r, ovf_nxt;
  logic [CntW-1:0] rank_r, rank_nxt;    // sort pass / nms box index
  logic [CntW-1:0] scan_r, scan_nxt;    // scan index within a pass
  logic [CntW-1:0] kcnt_r, kcnt_nxt;    // kept count
  logic [CntW-1:0] kj_r, kj_nxt;        // kept list scan index
  logic [ScoreW-1:0] best_s_r, best_s_nxt;
  logic [IdxW-1:0]   best_i_r, best_i_nxt;
  logic              best_v_r, best_v_nxt;
  logic [MaxBoxes-1:0] used_r, used_nxt;   // boxes already ranked
  logic              sup_r, sup_nxt;
  logic [IdxW-1:0]   cand_r, cand_nxt;     // box under test
  logic [CornerW-1:0] ca_r, ca_nxt;
  logic [AreaW-1:0]   aa_r, aa_nxt;
  // product stage
  logic signed [35:0] inter_r;
  logic signed [36:0] uni_r;
  logic out_v_r, out_v_nxt;
  out_item_t out_r, out_nxt;

  // Memories: corners, scores, areas, ranking order, kept list.
  logic              ld_we;
  logic [IdxW-1:0]   ld_addr;
  logic [CornerW-1:0] corner_rd;
  logic [ScoreW-1:0]  score_rd;
  logic [AreaW-1:0]   area_rd;
  logic [IdxW-1:0]    box_raddr;
  logic              ord_we;
  logic [IdxW-1:0]   ord_waddr, ord_raddr, ord_rd;
  logic              kl_we;
  logic [IdxW-1:0]   kl_waddr, kl_raddr, kl_rd;

  // A full-range box with the pixel offset spans 65551, so 18 signed bits.
  logic signed [17:0] w_in, h_in;
  logic signed [AreaW-1:0] area_in;
  assign w_in = 18'(in_data.right_x) - 18'(in_data.left_x) + (poff_r ? 18'sd16 : 18'sd0);
  assign h_in = 18'(in_data.bottom_y) - 18'(in_data.top_y) + (poff_r ? 18'sd16 : 18'sd0);
  assign area_in = AreaW'(w_in * h_in);

  assign ld_addr = n_r[IdxW-1:0];

  gbs_ram #(.Width(CornerW), .Depth(MaxBoxes)) u_corner (
    .clk, .we(ld_we), .waddr(ld_addr),
    .wdata({in_data.bottom_y, in_data.right_x, in_data.top_y, in_data.left_x}),
    .raddr(box_raddr), .rdata(corner_rd));
  gbs_ram #(.Width(ScoreW), .Depth(MaxBoxes)) u_score (
    .clk, .we(ld_we), .waddr(ld_addr), .wdata(in_data.box_score),
    .raddr(box_raddr), .rdata(score_rd));
  gbs_ram #(.Width(AreaW), .Depth(MaxBoxes)) u_area (
    .clk, .we(ld_we), .waddr(ld_addr), .wdata(area_in),
    .raddr(box_raddr), .rdata(area_rd));
  // The winner of a pass may be the box compared in the pass's last cycle,
  // so the order memory takes the next-state winner.
  gbs_ram #(.Width(IdxW), .Depth(MaxBoxes)) u_order (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(best_i_nxt),
    .raddr(ord_raddr), .rdata(ord_rd));
  gbs_ram #(.Width(IdxW), .Depth(MaxBoxes)) u_kept (
    .clk, .we(kl_we), .waddr(kl_waddr), .wdata(cand_r),
    .raddr(kl_raddr), .rdata(kl_rd));

  // Intersection of the candidate (ca_r) and the kept box on corner_rd.
  logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic signed [15:0] lx, ly, hx, hy;
  logic signed [17:0] iw, ih;
  logic [17:0] iwc, ihc;
  assign {ay2, ax2, ay1, ax1} = ca_r;
  assign {by2, bx2, by1, bx1} = corner_rd;
  assign lx = (ax1 > bx1) ? ax1 : bx1;
  assign ly = (ay1 > by1) ? ay1 : by1;
  assign hx = (ax2 < bx2) ? ax2 : bx2;
  assign hy = (ay2 < by2) ? ay2 : by2;
  assign iw = 18'(hx) - 18'(lx) + (poff_r ? 18'sd16 : 18'sd0);
  assign ih = 18'(hy) - 18'(ly) + (poff_r ? 18'sd16 : 18'sd0);
  assign iwc = iw[17] ? 18'd0 : iw;
  assign ihc = ih[17] ? 18'd0 : ih;

  // Threshold test on the registered products.
  logic signed [53:0] lhs, rhs;
  logic hit;
  assign lhs = 54'(inter_r) <<< 16;
  assign rhs = $signed({1'b0, thr_r}) * 54'(uni_r);
  always_comb begin
    if (uni_r <= 0) begin
      hit = inter_r > 0;
    end else begin
      hit = lhs >= rhs;
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_v_r && out_ready;
  assign in_ready = (state_r == ST_LOAD);
  assign out_valid = out_v_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (in_acc && in_data.is_last) state_nxt = ST_SORT_RD;
      ST_SORT_RD:  state_nxt = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (scan_r + 1'b1 < n_r) state_nxt = ST_SORT_CMP;
        else if (rank_r + 1'b1 < n_r) state_nxt = ST_SORT_RD;
        else state_nxt = ST_NMS_RD;
      end
      ST_NMS_RD:   state_nxt = ST_NMS_KRD;
      ST_NMS_KRD:  state_nxt = (kj_r < kcnt_r) ? ST_NMS_MUL : ST_NMS_WR;
      ST_NMS_MUL:  state_nxt = ST_NMS_PROD;
      ST_NMS_PROD: state_nxt = ST_NMS_CMP;
      ST_NMS_CMP:  state_nxt = (hit || kj_r + 1'b1 >= kcnt_r) ? ST_NMS_WR : ST_NMS_KRD;
      ST_NMS_WR:   state_nxt = (rank_r + 1'b1 < n_r) ? ST_NMS_RD : ST_EMIT_RD;
      ST_EMIT_RD:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc || !out_v_r) begin
          state_nxt = (kj_r >= kcnt_r) ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:     state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    n_nxt = n_r; ovf_nxt = ovf_r; rank_nxt = rank_r; scan_nxt = scan_r;
    kcnt_nxt = kcnt_r; kj_nxt = kj_r; best_s_nxt = best_s_r;
    best_i_nxt = best_i_r; best_v_nxt = best_v_r; used_nxt = used_r;
    sup_nxt = sup_r; cand_nxt = cand_r; ca_nxt = ca_r; aa_nxt = aa_r;
    out_v_nxt = out_v_r; out_nxt = out_r;
    ld_we = 1'b0; box_raddr = scan_r[IdxW-1:0];
    ord_we = 1'b0; ord_waddr = rank_r[IdxW-1:0]; ord_raddr = rank_r[IdxW-1:0];
    kl_we = 1'b0; kl_waddr = kcnt_r[IdxW-1:0]; kl_raddr = kj_r[IdxW-1:0];
    if (out_acc) out_v_nxt = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (n_r < CntW'(MaxBoxes)) begin
            ld_we = 1'b1;
            n_nxt = n_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          rank_nxt = '0; scan_nxt = '0; used_nxt = '0; best_v_nxt = 1'b0;
        end
      end
      ST_SORT_RD: begin
        // Start a selection pass: read score at scan_r.
        box_raddr = scan_r[IdxW-1:0];
        scan_nxt = scan_r;
      end
      ST_SORT_CMP: begin
        // score_rd belongs to scan_r; strict > keeps arrival order on ties.
        if (!used_r[scan_r[IdxW-1:0]] && (!best_v_r || score_rd > best_s_r)) begin
          best_v_nxt = 1'b1; best_s_nxt = score_rd; best_i_nxt = scan_r[IdxW-1:0];
        end
        box_raddr = IdxW'(scan_r + 1'b1);
        if (scan_r + 1'b1 < n_r) begin
          scan_nxt = scan_r + 1'b1;
        end else begin
          ord_we = 1'b1;
          if (!used_r[scan_r[IdxW-1:0]] && (!best_v_r || score_rd > best_s_r)) begin
            used_nxt[scan_r[IdxW-1:0]] = 1'b1;
          end else begin
            used_nxt[best_i_r] = 1'b1;
          end
          best_v_nxt = 1'b0;
          scan_nxt = '0;
          if (rank_r + 1'b1 < n_r) rank_nxt = rank_r + 1'b1;
          else begin
            rank_nxt = '0; kcnt_nxt = '0;
          end
        end
      end
      ST_NMS_RD: begin
        ord_raddr = rank_r[IdxW-1:0];
        kj_nxt = '0; sup_nxt = 1'b0;
      end
      ST_NMS_KRD: begin
        // ord_rd valid on first visit; fetch candidate, kept box follows.
        if (kj_r == '0) cand_nxt = ord_rd;
        kl_raddr = kj_r[IdxW-1:0];
        box_raddr = (kj_r == '0) ? ord_rd : cand_r;
      end
      ST_NMS_MUL: begin
        // corner_rd/area_rd hold the candidate; it is captured on the first
        // pair. The kept box read is issued here and lands in ST_NMS_PROD.
        box_raddr = kl_rd;
        if (kj_r == '0) begin
          ca_nxt = corner_rd; aa_nxt = area_rd;
        end
      end
      ST_NMS_CMP: begin
        if (hit) sup_nxt = 1'b1;
        kj_nxt = kj_r + 1'b1;
      end
      ST_NMS_WR: begin
        if (!sup_r) begin
          kl_we = 1'b1;
          kcnt_nxt = kcnt_r + 1'b1;
        end
        rank_nxt = rank_r + 1'b1;
        if (rank_r + 1'b1 >= n_r) kj_nxt = '0;
      end
      ST_EMIT_RD: begin
        kl_raddr = kj_r[IdxW-1:0];
      end
      ST_EMIT: begin
        kl_raddr = kj_r[IdxW-1:0];
        if (out_acc || !out_v_r) begin
          if (kj_r < kcnt_r) begin
            out_v_nxt = 1'b1;
            out_nxt.kept_index = kl_rd;
            out_nxt.kept_count = kcnt_r;
            out_nxt.last_kept = (kj_r + 1'b1 == kcnt_r);
            out_nxt.boxes_dropped = ovf_r;
            kj_nxt = kj_r + 1'b1;
          end else begin
            n_nxt = '0; ovf_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // In ST_NMS_PROD the kept box corners and area are on the memory ports and
  // the candidate sits in ca_r/aa_r; the products are registered there and
  // compared against the threshold in ST_NMS_CMP.
  logic signed [35:0] inter_c;
  assign inter_c = $signed({1'b0, iwc[16:0]}) * $signed({1'b0, ihc[16:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; n_r <= '0; ovf_r <= 1'b0; out_v_r <= 1'b0;
      rank_r <= '0; scan_r <= '0; kcnt_r <= '0; kj_r <= '0;
      best_v_r <= 1'b0; used_r <= '0; sup_r <= 1'b0;
    end else begin
      state_r <= state_nxt; n_r <= n_nxt; ovf_r <= ovf_nxt; out_v_r <= out_v_nxt;
      rank_r <= rank_nxt; scan_r <= scan_nxt; kcnt_r <= kcnt_nxt; kj_r <= kj_nxt;
      best_v_r <= best_v_nxt; used_r <= used_nxt; sup_r <= sup_nxt;
    end
    best_s_r <= best_s_nxt; best_i_r <= best_i_nxt; cand_r <= cand_nxt;
    ca_r <= (state_r == ST_NMS_MUL && kj_r == '0) ? ca_nxt : ca_r;
    aa_r <= (state_r == ST_NMS_MUL && kj_r == '0) ? aa_nxt : aa_r;
    out_r <= out_nxt;
    if (state_r == ST_NMS_PROD) begin
      inter_r <= inter_c;
      uni_r <= 37'($signed(aa_r)) + 37'($signed(area_rd)) - 37'(inter_c);
    end
  end
endmodule

// File: design/gbs_checker.sv
`timescale 1ns / 1ps
`include "greedy_box_suppression_defines.svh"
module gbs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input gbs_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input gbs_pkg::out_item_t out_data
);
  import gbs_pkg::*;
  // No box is taken while results are pending.
  `GBS_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input taken during output")
  // A stalled result holds.
  `GBS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data),
    "stalled result changed")
  // Input closes after the last box.
  `GBS_ASSERT_NEXT(a_close, in_valid && in_ready && in_data.is_last, !in_ready,
    "input open after last box")
  // Count is at least one.
  `GBS_ASSERT_IMP(a_count, out_valid, out_data.kept_count != 7'd0, "zero kept count")
endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data);

// File: verif/greedy_box_suppression_tb.sv
`timescale 1ns / 1ps
// Testbench for the greedy box suppression block. Boxes are sent in sets on
// the in_ channel; a local predictor ranks each closed set and works out the
// kept indices, which the checker compares with every item on the out_ side.
module greedy_box_suppression_tb;
  import gbs_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int InW = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = RegThreshold;
  logic [ThrW-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  greedy_box_suppression dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: the boxes of the set being loaded, with the area each
  // one got from pixel_offset at its arrival, and the register copies.
  in_item_t set_boxes[MaxBoxes];
  longint set_areas[MaxBoxes];
  int set_fill = 0;
  bit set_overflowed = 1'b0;
  logic [ThrW-1:0] thr_shadow = 17'd32768;
  bit offset_shadow = 1'b0;

  out_item_t kept_expected[$];
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    errors++;
  endtask

  function automatic longint box_span(input int lo, input int hi);
    return longint'(hi) - longint'(lo) + (offset_shadow ? 16 : 0);
  endfunction

  // True when ranked box a is removed by kept box b. The threshold and the
  // offset used for the intersection are the ones in force at is_last.
  function automatic bit overlap_suppresses(input int a, input int b);
    int lx, ly, hx, hy;
    longint w, h, inter, uni;
    lx = $signed(set_boxes[a].left_x) > $signed(set_boxes[b].left_x) ?
         $signed(set_boxes[a].left_x) : $signed(set_boxes[b].left_x);
    ly = $signed(set_boxes[a].top_y) > $signed(set_boxes[b].top_y) ?
         $signed(set_boxes[a].top_y) : $signed(set_boxes[b].top_y);
    hx = $signed(set_boxes[a].right_x) < $signed(set_boxes[b].right_x) ?
         $signed(set_boxes[a].right_x) : $signed(set_boxes[b].right_x);
    hy = $signed(set_boxes[a].bottom_y) < $signed(set_boxes[b].bottom_y) ?
         $signed(set_boxes[a].bottom_y) : $signed(set_boxes[b].bottom_y);
    w = box_span(lx, hx);
    h = box_span(ly, hy);
    if (w < 0) w = 0;
    if (h < 0) h = 0;
    inter = w * h;
    uni = set_areas[a] + set_areas[b] - inter;
    // A degenerate union suppresses only on a real overlap.
    if (uni <= 0) return inter > 0;
    return inter * 65536 >= longint'(thr_shadow) * uni;
  endfunction

  // Called for every accepted box. Closing the set ranks it, walks the
  // ranking and queues one expected item per kept box.
  task automatic predict_box(input in_item_t b);
    int rank[MaxBoxes];
    int kept[MaxBoxes];
    int nk, j;
    bit keep;
    out_item_t r;
    nk = 0;
    if (set_fill < MaxBoxes) begin
      set_boxes[set_fill] = b;
      set_areas[set_fill] = box_span($signed(b.left_x), $signed(b.right_x)) *
                            box_span($signed(b.top_y), $signed(b.bottom_y));
      set_fill++;
    end else begin
      set_overflowed = 1'b1;
    end
    if (!b.is_last) return;
    // Stable ranking by descending score.
    for (int i = 0; i < set_fill; i++) begin
      j = i;
      while (j > 0 && set_boxes[rank[j-1]].box_score < set_boxes[i].box_score) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
    for (int i = 0; i < set_fill; i++) begin
      keep = 1'b1;
      for (int k = 0; k < nk && keep; k++)
        if (overlap_suppresses(rank[i], kept[k])) keep = 1'b0;
      if (keep) kept[nk++] = rank[i];
    end
    for (int i = 0; i < nk; i++) begin
      r.kept_index = 6'(kept[i]);
      r.kept_count = 7'(nk);
      r.last_kept = (i == nk - 1);
      r.boxes_dropped = set_overflowed;
      kept_expected.push_back(r);
    end
    set_fill = 0;
    set_overflowed = 1'b0;
  endtask

  // Sends one box, after a random gap now and then, and waits for it to be
  // taken. Valid stays high only if the next box follows at once.
  task automatic send_box(input in_item_t b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    predict_box(b);
  endtask

  // Lets every expected item arrive, then idles so that the block is back in
  // its loading state before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (kept_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ThrW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegThreshold) thr_shadow = val;
    else offset_shadow = val[0];
    @(posedge clk);
  endtask

  function automatic in_item_t make_box(input int x1, input int y1, input int x2,
                                        input int y2, input int score, input bit last);
    in_item_t b;
    b.left_x = 16'(x1);
    b.top_y = 16'(y1);
    b.right_x = 16'(x2);
    b.bottom_y = 16'(y2);
    b.box_score = 16'(score);
    b.is_last = last;
    return b;
  endfunction

  // Mostly clustered boxes so that overlaps are common; now and then fully
  // random fields so every bit of every corner and score toggles.
  function automatic in_item_t random_box(input bit last);
    in_item_t b;
    int cx, cy, w, h, score;
    if ($urandom_range(0, 7) == 0) begin
      b = InW'({$urandom(), $urandom(), $urandom()});
      b.is_last = last;
      return b;
    end
    cx = $urandom_range(0, 800) - 400;
    cy = $urandom_range(0, 800) - 400;
    w = $urandom_range(0, 400);
    h = $urandom_range(0, 400);
    if ($urandom_range(0, 9) == 0) w = -w;
    if ($urandom_range(0, 9) == 0) h = -h;
    score = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) * 16384 + 1 : $urandom();
    return make_box(cx - w / 2, cy - h / 2, cx + w / 2, cy + h / 2, score, last);
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_box(random_box(i == n - 1));
  endtask

  // Field extremes, ties, inverted and zero-size boxes, default registers.
  task automatic test_directed_shapes();
    send_box(make_box(-32768, -32768, 32767, 32767, 65535, 1'b1));
    send_box(make_box(32767, 32767, -32768, -32768, 0, 1'b1));
    // Equal scores keep arrival order, so the second copy is removed.
    send_box(make_box(0, 0, 160, 160, 100, 1'b0));
    send_box(make_box(0, 0, 160, 160, 100, 1'b0));
    send_box(make_box(80, 0, 240, 160, 200, 1'b1));
    // Zero-size boxes have zero union and zero overlap: both kept.
    send_box(make_box(0, 0, 0, 0, 5, 1'b0));
    send_box(make_box(0, 0, 0, 0, 5, 1'b1));
    // Inverted box with negative area against a normal one.
    send_box(make_box(0, 0, 64, 64, 9, 1'b0));
    send_box(make_box(-32768, 64, 32767, 0, 10, 1'b0));
    send_box(make_box(0, 32767, 64, -32768, 8, 1'b1));
    wait_idle();
  endtask

  // Threshold extremes and the pixel offset, which turns zero-size boxes
  // into one-pixel boxes that overlap fully.
  task automatic test_directed_registers();
    write_reg(RegPixelOffset, 17'd1);
    write_reg(RegThreshold, 17'd65536);
    send_box(make_box(0, 0, 0, 0, 5, 1'b0));
    send_box(make_box(0, 0, 0, 0, 5, 1'b0));
    send_box(make_box(0, 0, 16, 0, 7, 1'b1));
    wait_idle();
    write_reg(RegThreshold, 17'd0);
    send_box(make_box(0, 0, 32, 32, 1, 1'b0));
    send_box(make_box(16, 16, 64, 64, 2, 1'b0));
    send_box(make_box(1000, 1000, 1100, 1100, 3, 1'b1));
    wait_idle();
    write_reg(RegPixelOffset, 17'd0);
    write_reg(RegThreshold, 17'h1FFFF);
    send_box(make_box(0, 0, 32, 32, 1, 1'b0));
    send_box(make_box(0, 0, 32, 32, 1, 1'b1));
    wait_idle();
    write_reg(RegThreshold, 17'd32768);
  endtask

  // One set whose final box falls beyond capacity, then one whose last two
  // boxes both fall beyond capacity.
  task automatic test_capacity_overflow();
    for (int i = 0; i <= MaxBoxes; i++)
      send_box(make_box(i * 64, 0, i * 64 + 48, 48, $urandom_range(0, 65535),
                        i == MaxBoxes));
    wait_idle();
    for (int i = 0; i < MaxBoxes + 2; i++)
      send_box(make_box(0, i * 8, 64, i * 8 + 64, i, i == MaxBoxes + 1));
    wait_idle();
  endtask

  // The receiver stops for a long time while sets keep coming, so the block
  // fills and holds in_ready low; then the sender waits for a full drain.
  task automatic test_output_stall();
    hold_left = 3000;
    repeat (3) send_random_set($urandom_range(2, 6));
    wait_idle();
  endtask

  // Random sets under several register settings; the last stretch runs
  // without any idling on either side.
  task automatic test_random_sets();
    logic [ThrW-1:0] thr;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: thr = 17'd0;
        1: thr = 17'd65536;
        2: thr = 17'h1FFFF;
        default: thr = ThrW'($urandom_range(0, 65536));
      endcase
      write_reg(RegThreshold, thr);
      write_reg(RegPixelOffset, ThrW'($urandom_range(0, 1)));
      if (phase == 5) calm = 1'b1;
      for (int s = 0; s < 3; s++) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        send_random_set(n);
      end
      wait_idle();
    end
  endtask

  // Receiver: random stall bursts, or a long hold when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every accepted result is matched against the oldest expected item.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (kept_expected.size() == 0) begin
        report_mismatch("unexpected result item, kept_index", -1, out_data.kept_index);
      end else begin
        out_item_t want;
        want = kept_expected.pop_front();
        if (out_data.kept_index !== want.kept_index)
          report_mismatch("kept_index", want.kept_index, out_data.kept_index);
        if (out_data.kept_count !== want.kept_count)
          report_mismatch("kept_count", want.kept_count, out_data.kept_count);
        if (out_data.last_kept !== want.last_kept)
          report_mismatch("last_kept", want.last_kept, out_data.last_kept);
        if (out_data.boxes_dropped !== want.boxes_dropped)
          report_mismatch("boxes_dropped", want.boxes_dropped, out_data.boxes_dropped);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_shapes();
    test_directed_registers();
    test_capacity_overflow();
    test_output_stall();
    test_random_sets();
    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+design
design/gbs_pkg.sv
design/gbs_ram.sv
design/greedy_box_suppression.sv
design/gbs_checker.sv
verif/greedy_box_suppression_tb.sv
